// ===== src/dfh_pkg.sv =====
// Package for the DEFLATE fixed-Huffman encoder: token and code types, command codes,
// the length and distance code tables and small helper functions.
// No dependencies.
`default_nettype none

package dfh_pkg;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_LITERAL = 2'd1;
  localparam logic [1:0] CMD_MATCH   = 2'd2;
  localparam logic [1:0] CMD_END     = 2'd3;

  localparam int LEN_CODES  = 29;
  localparam int DIST_CODES = 30;

  // Fixed code table boundaries (RFC 1951).
  localparam logic [7:0] LIT_CODE8_BASE   = 8'h30;
  localparam logic [8:0] LIT_CODE9_BASE   = 9'h190;
  localparam logic [7:0] LEN_CODE8_BASE   = 8'hC0;
  localparam logic [7:0] LIT_LAST_8BIT    = 8'd143;
  localparam logic [8:0] LIT_FIRST_9BIT   = 9'd144;
  localparam logic [4:0] LEN_LAST_7BIT    = 5'd22;   // symbol 279 = 257 + 22
  localparam logic [4:0] LEN_FIRST_8BIT   = 5'd23;   // symbol 280 = 257 + 23

  localparam logic [8:0]  LEN_MIN  = 9'd3;
  localparam logic [8:0]  LEN_MAX  = 9'd258;
  localparam logic [15:0] DIST_MIN = 16'd1;
  localparam logic [15:0] DIST_MAX = 16'd32768;

  localparam logic [8:0] LEN_LOW [LEN_CODES] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
    9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
    9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258};
  localparam logic [2:0] LEN_XBITS [LEN_CODES] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd0};
  localparam logic [15:0] DIST_LOW [DIST_CODES] = '{
    16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
    16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
    16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
    16'd8193, 16'd12289, 16'd16385, 16'd24577};
  localparam logic [3:0] DIST_XBITS [DIST_CODES] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  literal_byte;
    logic [8:0]  match_length;
    logic [15:0] match_distance;
  } item_t;

  // Bits of one token in stream order (first bit in bit 0), their count, and
  // whether the partial byte is to be padded out afterwards.
  typedef struct packed {
    logic [30:0] bits;
    logic [4:0]  nbits;
    logic        flush;
  } code_t;

  function automatic logic [4:0] len_code(input logic [8:0] len);
    logic [4:0] lc;
    lc = '0;
    for (int i = 1; i < LEN_CODES; i++) begin
      if (len >= LEN_LOW[i]) lc = 5'(i);
    end
    return lc;
  endfunction

  function automatic logic [4:0] dist_code(input logic [15:0] distance);
    logic [4:0] dc;
    dc = '0;
    for (int i = 1; i < DIST_CODES; i++) begin
      if (distance >= DIST_LOW[i]) dc = 5'(i);
    end
    return dc;
  endfunction

  // Huffman codes go out most significant bit first, so they are mirrored.
  function automatic logic [4:0] rev5(input logic [4:0] c);
    logic [4:0] r;
    for (int i = 0; i < 5; i++) r[i] = c[4-i];
    return r;
  endfunction

  function automatic logic [6:0] rev7(input logic [6:0] c);
    logic [6:0] r;
    for (int i = 0; i < 7; i++) r[i] = c[6-i];
    return r;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] c);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = c[7-i];
    return r;
  endfunction

  function automatic logic [8:0] rev9(input logic [8:0] c);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) r[i] = c[8-i];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/dfh_symbol.sv =====
// Token encoder: turns one registered token into its fixed-Huffman bit string.
// Depends on dfh_pkg.
`default_nettype none

module dfh_symbol import dfh_pkg::*; (
  input  item_t item,
  input  logic  final_block,
  output code_t code
);

  logic [8:0]  len_c;
  logic [15:0] dist_c;
  logic [4:0]  lc;
  logic [4:0]  dc;
  logic [8:0]  lcode_rev;
  logic [3:0]  lcode_n;
  logic [4:0]  lext;
  logic [2:0]  lext_n;
  logic [12:0] dext;
  logic [3:0]  dext_n;
  logic [4:0]  pos1;
  logic [4:0]  pos2;
  logic [30:0] mbits;
  logic [8:0]  lit9;

  always_comb begin
    len_c = item.match_length;
    if (len_c < LEN_MIN) len_c = LEN_MIN;
    if (len_c > LEN_MAX) len_c = LEN_MAX;
    dist_c = item.match_distance;
    if (dist_c < DIST_MIN) dist_c = DIST_MIN;
    if (dist_c > DIST_MAX) dist_c = DIST_MAX;

    lc = len_code(len_c);
    dc = dist_code(dist_c);

    if (lc <= LEN_LAST_7BIT) begin
      lcode_rev = {2'b00, rev7(7'(lc + 5'd1))};
      lcode_n   = 4'd7;
    end else begin
      lcode_rev = {1'b0, rev8(LEN_CODE8_BASE + 8'(lc - LEN_FIRST_8BIT))};
      lcode_n   = 4'd8;
    end
    lext   = 5'(len_c - LEN_LOW[lc]);
    lext_n = LEN_XBITS[lc];
    dext   = 13'(dist_c - DIST_LOW[dc]);
    dext_n = DIST_XBITS[dc];

    // Length code, length extra bits, distance code, distance extra bits.
    pos1  = 5'(lcode_n) + 5'(lext_n);
    pos2  = pos1 + 5'd5;
    mbits = 31'(lcode_rev)
          | (31'(lext) << lcode_n)
          | (31'(rev5(dc)) << pos1)
          | (31'(dext) << pos2);

    lit9 = LIT_CODE9_BASE + 9'(item.literal_byte) - LIT_FIRST_9BIT;

    code = '0;
    case (item.command)
      CMD_START: begin
        code.bits  = {28'd0, 1'b0, 1'b1, final_block};
        code.nbits = 5'd3;
      end
      CMD_LITERAL: begin
        if (item.literal_byte <= LIT_LAST_8BIT) begin
          code.bits  = 31'(rev8(LIT_CODE8_BASE + item.literal_byte));
          code.nbits = 5'd8;
        end else begin
          code.bits  = 31'(rev9(lit9));
          code.nbits = 5'd9;
        end
      end
      CMD_MATCH: begin
        code.bits  = mbits;
        code.nbits = pos2 + 5'(dext_n);
      end
      default: begin
        // End of block: symbol 256 is seven zero bits.
        code.bits  = '0;
        code.nbits = 5'd7;
        code.flush = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/dfh_pack.sv =====
// Bit packer: appends a token's code to the pending bits, splits off whole bytes
// into a four-byte buffer and drains it one byte per transaction. Depends on dfh_pkg.
`default_nettype none

module dfh_pack import dfh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       code_valid,
  input  code_t      code,
  output logic       code_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [6:0]  pend_r, pend_nxt;
  logic [2:0]  pcnt_r, pcnt_nxt;
  logic [31:0] buf_r, buf_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  logic [37:0] merged;
  logic [37:0] shifted;
  logic [5:0]  total;
  logic [5:0]  total_adj;
  logic [2:0]  nbytes;
  logic        load;
  logic        pop;

  assign out_valid  = (cnt_r != 3'd0);
  assign out_byte   = buf_r[7:0];
  assign out_last   = (cnt_r == 3'd1);
  assign pop        = out_valid && out_ready;
  // A new token may land once the buffer is empty or its last byte leaves now.
  assign code_ready = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ready);
  assign load       = code_valid && code_ready;

  always_comb begin
    merged = 38'(pend_r) | (38'(code.bits) << pcnt_r);
    total  = 6'(pcnt_r) + 6'(code.nbits);
    total_adj = total;
    if (code.flush && total[2:0] != 3'd0) begin
      total_adj = {total[5:3] + 3'd1, 3'b000};
    end
    nbytes  = total_adj[5:3];
    shifted = merged >> {nbytes, 3'b000};

    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      pend_nxt = shifted[6:0];
      pcnt_nxt = total_adj[2:0];
      buf_nxt  = merged[31:0];
      cnt_nxt  = nbytes;
    end else if (pop) begin
      buf_nxt = {8'd0, buf_r[31:8]};
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

`default_nettype wire

// ===== src/deflate_fixed_huffman_encoder.sv =====
// Top level of the DEFLATE fixed-Huffman encoder: input and code registers,
// the BFINAL register, token encoder and bit packer. Depends on dfh_pkg,
// dfh_symbol and dfh_pack.
`default_nettype none

// Takes LZ77 tokens (start block, literal, match, end block) and produces the
// fixed-Huffman DEFLATE stream as bytes, least significant bit first. A token
// may be accepted every cycle while the output buffer does not hold back the
// pipeline; it passes the input register, the code register and lands in a
// four-byte output buffer, from which its bytes are offered. The byte-wide
// result port sets the sustained rate: a token that completes more than one byte
// holds the buffer until its last byte is taken, and a long match completes up
// to four bytes. The last byte that each token completes carries out_last_of_run.
// cfg_final_block sets BFINAL for later start tokens and must be written only
// while the encoder is idle; the block itself does not enforce this.
module deflate_fixed_huffman_encoder import dfh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_final_block,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_literal_byte,
  input  logic [8:0]  in_match_length,
  input  logic [15:0] in_match_distance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run
);

  logic  final_block_r;
  logic  s1_v_r;
  item_t s1_item_r;
  logic  s2_v_r;
  code_t s2_code_r;
  code_t enc_code;
  logic  s1_ready;
  logic  s2_ready;

  assign cfg_ready = 1'b1;
  assign s1_ready  = !s2_v_r || s2_ready;
  assign in_ready  = !s1_v_r || s1_ready;

  dfh_symbol u_symbol (
    .item        (s1_item_r),
    .final_block (final_block_r),
    .code        (enc_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      final_block_r <= 1'b1;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
    end else begin
      if (cfg_valid) final_block_r <= cfg_final_block;
      if (in_ready) s1_v_r <= in_valid;
      if (s1_ready) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{command:        in_command,
                     literal_byte:   in_literal_byte,
                     match_length:   in_match_length,
                     match_distance: in_match_distance};
    end
    if (s1_v_r && s1_ready) s2_code_r <= enc_code;
  end

  dfh_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .code_valid (s2_v_r),
    .code       (s2_code_r),
    .code_ready (s2_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last_of_run)
  );

endmodule

`default_nettype wire

// ===== src/dfh_checker.sv =====
// Port-level checks for the DEFLATE fixed-Huffman encoder, bound to its top level.
// Depends only on the top level's port names.
`default_nettype none

module dfh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_command,
  input wire logic [7:0]  in_literal_byte,
  input wire logic [8:0]  in_match_length,
  input wire logic [15:0] in_match_distance,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic        out_last_of_run
);

  // A stalled result transaction keeps its byte and marker.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // A waiting input transaction keeps its token.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_command) && $stable(in_literal_byte)
      && $stable(in_match_length) && $stable(in_match_distance))
    else $error("input token changed while waiting");

  // A byte that is not the last of its token is always followed by another.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("token run ended without a last byte");

  // Reset leaves no result pending and the input open.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("state not cleared by reset");

  // The configuration register takes a write in any cycle.
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind deflate_fixed_huffman_encoder dfh_checker u_dfh_checker (.*);

`default_nettype wire
